/* design/slcd_pkg.sv */
// ----------------------------------------------------------------------------
// slcd_pkg: shared types and constants of the sync/length/checksum deframer
// Holds the phase codes, register indexes, reset values and the structs that
// pass frame state and result items between the step logic and the top level.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned PhaseWidth = 3;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [PhaseWidth-1:0] PH_HUNT    = 3'd0;
    localparam logic [PhaseWidth-1:0] PH_SYNC2   = 3'd1;
    localparam logic [PhaseWidth-1:0] PH_SOURCE  = 3'd2;
    localparam logic [PhaseWidth-1:0] PH_ID      = 3'd3;
    localparam logic [PhaseWidth-1:0] PH_LENGTH  = 3'd4;
    localparam logic [PhaseWidth-1:0] PH_PAYLOAD = 3'd5;

    localparam logic [CfgIdxWidth-1:0] REG_SYNC_FIRST     = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_SYNC_SECOND    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_SYNC_ALTERNATE = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_SOURCE_LOW     = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_SOURCE_HIGH    = 3'd4;

    localparam logic [ByteWidth-1:0] RST_SYNC_FIRST     = 8'd128;
    localparam logic [ByteWidth-1:0] RST_SYNC_SECOND    = 8'd129;
    localparam logic [ByteWidth-1:0] RST_SYNC_ALTERNATE = 8'd181;
    localparam logic [ByteWidth-1:0] RST_SOURCE_LOW     = 8'd121;
    localparam logic [ByteWidth-1:0] RST_SOURCE_HIGH    = 8'd127;

    typedef struct packed {
        logic [ByteWidth-1:0] sync_first;
        logic [ByteWidth-1:0] sync_second;
        logic [ByteWidth-1:0] sync_alternate;
        logic [ByteWidth-1:0] source_low;
        logic [ByteWidth-1:0] source_high;
    } cfg_t;

    typedef struct packed {
        logic [PhaseWidth-1:0] phase;
        logic [ByteWidth-1:0]  bytes_seen;
        logic [ByteWidth-1:0]  running_sum;
        logic [ByteWidth-1:0]  saved_source;
        logic [ByteWidth-1:0]  saved_id;
        logic [ByteWidth-1:0]  saved_length;
        logic                  started_alternate;
    } frame_state_t;

    typedef struct packed {
        logic                 valid;
        logic [ByteWidth-1:0] payload_byte;
        logic [ByteWidth-1:0] payload_index;
        logic                 frame_end;
        logic                 checksum_ok;
        logic                 alternate_start;
        logic [ByteWidth-1:0] source_address;
        logic [ByteWidth-1:0] message_id;
        logic [ByteWidth-1:0] payload_length;
    } result_t;

endpackage

/* design/slcd_step.sv */
// ----------------------------------------------------------------------------
// slcd_step: per-byte frame parser step
// From the current frame state, the registers and one received byte, works
// out the next frame state and the result item that the byte causes, if any.
// ----------------------------------------------------------------------------
module slcd_step (
    input  slcd_pkg::cfg_t         cfg,
    input  slcd_pkg::frame_state_t state,
    input  logic [7:0]             rx_byte,
    output slcd_pkg::frame_state_t state_next,
    output slcd_pkg::result_t      result
);
    import slcd_pkg::*;

    always_comb
    begin
        state_next = state;
        result = '0;
        result.alternate_start = state.started_alternate;
        result.source_address  = state.saved_source;
        result.message_id      = state.saved_id;
        result.payload_length  = state.saved_length;
        result.payload_byte    = rx_byte;

        unique case (state.phase)
            PH_SYNC2:
            begin
                if (rx_byte == cfg.sync_second)
                begin
                    state_next.phase = PH_SOURCE;
                end
                else if (rx_byte == cfg.sync_alternate)
                begin
                    state_next.started_alternate = 1'b1;
                    state_next.phase = PH_SYNC2;
                end
                else
                begin
                    state_next.phase = PH_HUNT;
                end
            end
            PH_SOURCE:
            begin
                if ((rx_byte >= cfg.source_low) && (rx_byte <= cfg.source_high))
                begin
                    state_next.saved_source = rx_byte;
                    state_next.running_sum  = rx_byte;
                    state_next.phase = PH_ID;
                end
                else
                begin
                    state_next.phase = PH_HUNT;
                end
            end
            PH_ID:
            begin
                state_next.saved_id    = rx_byte;
                state_next.running_sum = state.running_sum + rx_byte;
                state_next.phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                state_next.saved_length = rx_byte;
                state_next.running_sum  = state.running_sum + rx_byte;
                state_next.bytes_seen   = '0;
                state_next.phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                result.valid = 1'b1;
                if (state.bytes_seen < state.saved_length)
                begin
                    result.payload_index   = state.bytes_seen;
                    state_next.running_sum = state.running_sum + rx_byte;
                    state_next.bytes_seen  = state.bytes_seen + 8'd1;
                end
                else
                begin
                    result.payload_index = state.saved_length;
                    result.frame_end     = 1'b1;
                    result.checksum_ok   = (rx_byte == state.running_sum)
                                           && !state.started_alternate;
                    state_next.phase = PH_HUNT;
                end
            end
            default:
            begin
                if (rx_byte == cfg.sync_first)
                begin
                    state_next.started_alternate = 1'b0;
                    state_next.phase = PH_SYNC2;
                end
                else
                begin
                    state_next.phase = PH_HUNT;
                end
            end
        endcase
    end

endmodule

/* design/sync_length_checksum_deframer_unit.sv */
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit: sync/length framed byte stream deframer
// Hunts for frames in a received byte stream and streams out payload bytes
// with their index, followed by an end item carrying the checksum result.
// ----------------------------------------------------------------------------
// The block takes one byte in every clock cycle in which in_ready is high. Each
// byte is parsed in the cycle it is accepted and any result item appears in the
// output register on the next cycle. Input ready is high whenever the output
// register is empty or its item is being taken in the same cycle, so the rate
// is set only by the downstream side taking items.
module sync_length_checksum_deframer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic       frame_end,
    output logic       checksum_ok,
    output logic       alternate_start,
    output logic [7:0] source_address,
    output logic [7:0] message_id,
    output logic [7:0] payload_length
);
    import slcd_pkg::*;

    cfg_t         cfg_reg;
    frame_state_t state_reg;
    frame_state_t state_next;
    result_t      step_result;
    result_t      out_reg;
    logic         out_valid_reg;
    logic         in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first     <= RST_SYNC_FIRST;
            cfg_reg.sync_second    <= RST_SYNC_SECOND;
            cfg_reg.sync_alternate <= RST_SYNC_ALTERNATE;
            cfg_reg.source_low     <= RST_SOURCE_LOW;
            cfg_reg.source_high    <= RST_SOURCE_HIGH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:     cfg_reg.sync_first     <= cfg_data;
                REG_SYNC_SECOND:    cfg_reg.sync_second    <= cfg_data;
                REG_SYNC_ALTERNATE: cfg_reg.sync_alternate <= cfg_data;
                REG_SOURCE_LOW:     cfg_reg.source_low     <= cfg_data;
                REG_SOURCE_HIGH:    cfg_reg.source_high    <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    slcd_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .rx_byte    (rx_byte),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_fire && step_result.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && step_result.valid)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_byte    = out_reg.payload_byte;
    assign payload_index   = out_reg.payload_index;
    assign frame_end       = out_reg.frame_end;
    assign checksum_ok     = out_reg.checksum_ok;
    assign alternate_start = out_reg.alternate_start;
    assign source_address  = out_reg.source_address;
    assign message_id      = out_reg.message_id;
    assign payload_length  = out_reg.payload_length;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while the output register is empty");

    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && step_result.valid && step_result.frame_end)
        |=> (state_reg.phase == PH_HUNT))
        else $error("parser did not return to the hunt after a frame end");

    a_ok_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.frame_end) |-> !out_reg.checksum_ok)
        else $error("checksum pass flagged on a payload item");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.frame_end)
        |-> (out_reg.payload_index < out_reg.payload_length))
        else $error("payload index beyond the declared length");

    a_alternate_never_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.alternate_start) |-> !out_reg.checksum_ok)
        else $error("alternate-start frame reported a checksum pass");

endmodule
